// File: rtl/core/teh_pkg.sv
// teh_pkg: shared types and constants of the timed event heap queue
// no dependencies
package teh_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int HANDLE_BITS = 8;
    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = 64 + 32 + HANDLE_BITS;

    typedef enum logic [1:0] {
        ST_SCHEDULED = 2'd0,
        ST_FULL      = 2'd1,
        ST_WOKEN     = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef struct packed {
        logic        mode;
        logic [7:0]  thread_handle;
        logic [31:0] tick_delay;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  woken_handle;
        logic [63:0] event_time;
        logic [63:0] now_ticks;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic [63:0]            wake;
        logic [31:0]            order;
        logic [HANDLE_BITS-1:0] handle;
    } entry_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic [IDX_W-1:0] raddr_a;
        logic [IDX_W-1:0] raddr_b;
    } mem_ctl_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_POP_RD,
        S_POP_ROOT,
        S_POP_MOVE,
        S_DN_RD,
        S_DN_CMP,
        S_DN_SWAP,
        S_NEXT_RD,
        S_NEXT_CHK
    } state_t;

    function automatic logic earlier(entry_t a, entry_t b);
        if (a.wake != b.wake)
            return a.wake < b.wake;
        return a.order < b.order;
    endfunction

endpackage

// File: rtl/core/teh_heap_mem.sv
// teh_heap_mem: heap storage, one write port and two registered read ports
// depends on teh_pkg
module teh_heap_mem
    import teh_pkg::*;
(
    input  logic     clk,
    input  mem_ctl_t ctl,
    output entry_t   rdata_a,
    output entry_t   rdata_b
);

    entry_t mem [QUEUE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.we)
            mem[ctl.waddr] <= ctl.wdata;
        rdata_a <= mem[ctl.raddr_a];
        rdata_b <= mem[ctl.raddr_b];
    end

endmodule

// File: rtl/core/teh_ctrl.sv
// teh_ctrl: sequencer for heap insert, pop and sift passes
// depends on teh_pkg; drives teh_heap_mem
module teh_ctrl
    import teh_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  cmd_t     cmd,
    output logic     busy,
    output logic     valid,
    output rsp_t     result,
    output mem_ctl_t mctl,
    input  entry_t   rd_a,
    input  entry_t   rd_b
);

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0] ord_reg, ord_next;
    logic [63:0] now_reg, now_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    entry_t cur_reg, cur_next;
    logic [63:0] due_reg, due_next;
    logic [CNT_W-1:0] nout_reg, nout_next;
    logic valid_reg, valid_next;
    rsp_t res_reg, res_next;

    logic [64:0] sum;
    logic [63:0] wake;
    logic [IDX_W-1:0] up_idx;
    logic [IDX_W:0] lc, rc;
    logic l_ok, r_ok;
    entry_t best;
    logic [IDX_W-1:0] best_idx;
    logic [CNT_W-1:0] cnt_dec;

    assign sum = {1'b0, now_reg} + {33'd0, cmd.tick_delay};
    assign wake = sum[64] ? {64{1'b1}} : sum[63:0];
    assign up_idx = (pos_reg - {{(IDX_W-1){1'b0}}, 1'b1}) >> 1;
    assign lc = {pos_reg, 1'b1};
    assign rc = {pos_reg, 1'b0} + {{IDX_W{1'b0}}, 1'b1} + {{IDX_W{1'b0}}, 1'b1};
    assign l_ok = lc < (IDX_W+1)'(cnt_reg);
    assign r_ok = rc < (IDX_W+1)'(cnt_reg);
    assign cnt_dec = cnt_reg - {{(CNT_W-1){1'b0}}, 1'b1};

    always_comb
    begin
        best = cur_reg;
        best_idx = pos_reg;
        if (l_ok && earlier(rd_a, best))
        begin
            best = rd_a;
            best_idx = lc[IDX_W-1:0];
        end
        if (r_ok && earlier(rd_b, best))
        begin
            best = rd_b;
            best_idx = rc[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            ord_reg <= '0;
            now_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            ord_reg <= ord_next;
            now_reg <= now_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        cur_reg <= cur_next;
        due_reg <= due_next;
        nout_reg <= nout_next;
        res_reg <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        ord_next = ord_reg;
        now_next = now_reg;
        pos_next = pos_reg;
        cur_next = cur_reg;
        due_next = due_reg;
        nout_next = nout_reg;
        valid_next = 1'b0;
        res_next = res_reg;
        mctl = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    res_next = '0;
                    res_next.now_ticks = now_reg;
                    res_next.last = 1'b1;
                    if (!cmd.mode)
                    begin
                        res_next.event_time = wake;
                        if (cnt_reg >= CNT_W'(QUEUE_DEPTH))
                        begin
                            res_next.status = ST_FULL;
                            valid_next = 1'b1;
                        end
                        else
                        begin
                            cur_next.wake = wake;
                            cur_next.order = ord_reg;
                            cur_next.handle = cmd.thread_handle[HANDLE_BITS-1:0];
                            ord_next = ord_reg + 32'd1;
                            pos_next = cnt_reg[IDX_W-1:0];
                            cnt_next = cnt_reg + {{(CNT_W-1){1'b0}}, 1'b1};
                            res_next.status = ST_SCHEDULED;
                            state_next = S_UP_RD;
                        end
                    end
                    else if (cnt_reg == '0)
                    begin
                        res_next.status = ST_EMPTY;
                        valid_next = 1'b1;
                    end
                    else
                    begin
                        nout_next = '0;
                        state_next = S_POP_RD;
                    end
                end
            end
            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    mctl.we = 1'b1;
                    mctl.waddr = pos_reg;
                    mctl.wdata = cur_reg;
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    mctl.raddr_a = up_idx;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                mctl.we = 1'b1;
                mctl.waddr = pos_reg;
                if (earlier(cur_reg, rd_a))
                begin
                    mctl.wdata = rd_a;
                    pos_next = up_idx;
                    state_next = S_UP_RD;
                end
                else
                begin
                    mctl.wdata = cur_reg;
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_POP_RD:
            begin
                mctl.raddr_a = '0;
                mctl.raddr_b = cnt_dec[IDX_W-1:0];
                state_next = S_POP_ROOT;
            end
            S_POP_ROOT:
            begin
                due_next = rd_a.wake;
                now_next = rd_a.wake;
                res_next = '0;
                res_next.status = ST_WOKEN;
                res_next.woken_handle = 8'(rd_a.handle);
                res_next.event_time = rd_a.wake;
                res_next.now_ticks = rd_a.wake;
                cur_next = rd_b;
                cnt_next = cnt_dec;
                nout_next = nout_reg + {{(CNT_W-1){1'b0}}, 1'b1};
                pos_next = '0;
                state_next = S_POP_MOVE;
            end
            S_POP_MOVE:
            begin
                if (cnt_reg == '0)
                begin
                    res_next.last = 1'b1;
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    mctl.raddr_a = lc[IDX_W-1:0];
                    mctl.raddr_b = rc[IDX_W-1:0];
                    state_next = S_DN_CMP;
                end
            end
            S_DN_RD:
            begin
                mctl.raddr_a = lc[IDX_W-1:0];
                mctl.raddr_b = rc[IDX_W-1:0];
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                mctl.we = 1'b1;
                mctl.waddr = pos_reg;
                mctl.wdata = best;
                if (best_idx == pos_reg)
                    state_next = S_NEXT_RD;
                else
                begin
                    pos_next = best_idx;
                    state_next = S_DN_SWAP;
                end
            end
            S_DN_SWAP:
            begin
                mctl.we = 1'b1;
                mctl.waddr = pos_reg;
                mctl.wdata = cur_reg;
                mctl.raddr_a = lc[IDX_W-1:0];
                mctl.raddr_b = rc[IDX_W-1:0];
                state_next = S_DN_CMP;
            end
            S_NEXT_RD:
            begin
                mctl.raddr_a = '0;
                mctl.raddr_b = cnt_dec[IDX_W-1:0];
                state_next = S_NEXT_CHK;
            end
            S_NEXT_CHK:
            begin
                mctl.raddr_a = '0;
                mctl.raddr_b = cnt_dec[IDX_W-1:0];
                valid_next = 1'b1;
                if (rd_a.wake == due_reg && nout_reg < CNT_W'(QUEUE_DEPTH))
                begin
                    res_next.last = 1'b0;
                    state_next = S_POP_ROOT;
                end
                else
                begin
                    res_next.last = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign valid = valid_reg;
    assign result = res_reg;

endmodule

// File: rtl/core/timed_event_heap_queue_unit.sv
// timed_event_heap_queue_unit: top level of the timed event heap queue
// depends on teh_pkg, teh_ctrl, teh_heap_mem
//
// a command beat is taken when start is high and busy is low
// mode 0 schedules a handle at now plus delay (saturating), one result
// mode 1 advances to the earliest wake time and returns every entry due
// at that time, one result per entry, last set on the final one
// each result is on the result port for one cycle with done high
// the receiver cannot stall; results are never held
// schedule: the result follows the sift-up loop, which steps S_UP_RD and
// S_UP_CMP in turn through the single heap memory
// advance: the root and last entry are read first, then each woken entry
// is taken and the moved entry sinks; a lone entry gives its result without a sift
// empty or full: result in the cycle after the beat
// reset clears the entry count, the order counter and the time;
// the heap memory itself needs no clearing
// busy stays high until the final result of a beat is shown
module timed_event_heap_queue_unit
    import teh_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  cmd_t cmd,
    output logic busy,
    output logic done,
    output rsp_t result
);

    mem_ctl_t mctl;
    entry_t rd_a, rd_b;

    teh_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .valid  (done),
        .result (result),
        .mctl   (mctl),
        .rd_a   (rd_a),
        .rd_b   (rd_b)
    );

    teh_heap_mem u_mem (
        .clk     (clk),
        .ctl     (mctl),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

`ifndef NO_ASSERTIONS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd.mode || !busy)) |=> (busy || done))
        else $error("beat produced neither work nor result");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.last) |-> !busy)
        else $error("busy after last result");
    a_woken_now: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_WOKEN) |-> (result.event_time == result.now_ticks))
        else $error("woken entry time differs from now");
`endif

endmodule
